// ===== rtl/core/pqls_pkg.sv =====
// ----------------------------------------------------------------------------
// pqls_pkg
// Shared types, codes and constants of the linear-scan priority queue.
// ----------------------------------------------------------------------------
package pqls_pkg;

   // default number of entries
   localparam int DEPTH_DEFAULT = 16;

   // field widths of the request and response transfers
   localparam int OP_W   = 2;
   localparam int DATA_W = 32;
   localparam int STAT_W = 2;
   localparam int SLOT_W = 4;
   localparam int OCC_W  = 5;

   // operation codes; code 3 is unused and does nothing
   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2
   } op_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // one stored entry
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       enq;
      logic       scan_start;
      logic       scan_rd;
      logic       shift_start;
      logic       shift_rd;
      logic       dec;
      logic       rsp_load;
      logic       rsp_found;
      status_type rsp_status;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic idx_last;
      logic best_last;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== rtl/core/pqls_channels.sv =====
// ----------------------------------------------------------------------------
// pqls channels
// Valid/ready channel interfaces for the request and response transfers.
// ----------------------------------------------------------------------------
interface pqls_req_if;
   logic                                valid;
   logic                                ready;
   logic [pqls_pkg::OP_W-1:0]           operation;
   logic signed [pqls_pkg::DATA_W-1:0]  item_value;
   logic signed [pqls_pkg::DATA_W-1:0]  item_priority;

   modport source (output valid, operation, item_value, item_priority, input ready);
   modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

interface pqls_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pqls_pkg::STAT_W-1:0]         status;
   logic signed [pqls_pkg::DATA_W-1:0]  out_value;
   logic signed [pqls_pkg::DATA_W-1:0]  out_priority;
   logic [pqls_pkg::SLOT_W-1:0]         out_slot;
   logic [pqls_pkg::OCC_W-1:0]          occupancy;
   logic                                is_empty;

   modport source (output valid, status, out_value, out_priority, out_slot, occupancy,
                   is_empty, input ready);
   modport sink   (input valid, status, out_value, out_priority, out_slot, occupancy,
                   is_empty, output ready);
endinterface

// ===== rtl/core/pqls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqls_ctrl
// Controller: decodes each request and steps the datapath through the scan,
// the shift-down on removal and the response load.
// ----------------------------------------------------------------------------
module pqls_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [pqls_pkg::OP_W-1:0] req_operation,
   output logic                      req_ready,
   input  pqls_pkg::stat_type        stat,
   output pqls_pkg::cmd_type         cmd
);
   import pqls_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_LAST,
      S_DEQ_SETUP,
      S_SHIFT,
      S_SHIFT_LAST,
      S_RESULT
   } state_type;

   state_type  state_ff, state_in;
   logic       deq_ff, deq_in;
   logic       found_ff, found_in;
   status_type status_ff, status_in;

   // next state and commands
   always_comb begin
      cmd            = '0;
      cmd.rsp_found  = found_ff;
      cmd.rsp_status = status_ff;
      state_in       = state_ff;
      deq_in         = deq_ff;
      found_in       = found_ff;
      status_in      = status_ff;
      req_ready      = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               found_in  = 1'b0;
               status_in = ST_OK;
               deq_in    = (req_operation == OP_DEQUEUE);
               state_in  = S_RESULT;
               unique case (req_operation)
                  OP_ENQUEUE: begin
                     if (stat.full) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.enq = 1'b1;
                     end
                  end
                  OP_DEQUEUE, OP_PEEK: begin
                     if (stat.empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.idx_last) begin
               state_in = S_SCAN_LAST;
            end
         end
         S_SCAN_LAST: begin
            found_in = 1'b1;
            state_in = deq_ff ? S_DEQ_SETUP : S_RESULT;
         end
         S_DEQ_SETUP: begin
            if (stat.best_last) begin
               cmd.dec  = 1'b1;
               state_in = S_RESULT;
            end else begin
               cmd.shift_start = 1'b1;
               state_in        = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift_rd = 1'b1;
            if (stat.idx_last) begin
               state_in = S_SHIFT_LAST;
            end
         end
         S_SHIFT_LAST: begin
            cmd.dec  = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered decode
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         deq_ff    <= 1'b0;
         found_ff  <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         deq_ff    <= deq_in;
         found_ff  <= found_in;
         status_ff <= status_in;
      end
   end

endmodule

// ===== rtl/core/pqls_datapath.sv =====
// ----------------------------------------------------------------------------
// pqls_datapath
// Entry memory, fill count, scan comparator with best-entry registers,
// shift-down write path and the response register.
// ----------------------------------------------------------------------------
module pqls_datapath #(
   parameter int DEPTH = pqls_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [pqls_pkg::DATA_W-1:0]  req_value,
   input  logic signed [pqls_pkg::DATA_W-1:0]  req_prio,
   input  pqls_pkg::cmd_type                   cmd,
   output pqls_pkg::stat_type                  stat,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [pqls_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [pqls_pkg::DATA_W-1:0]  rsp_value,
   output logic signed [pqls_pkg::DATA_W-1:0]  rsp_prio,
   output logic [pqls_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [pqls_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                                rsp_is_empty
);
   import pqls_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type              mem [DEPTH];

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   entry_type              rd_data_ff;
   logic                   cmp_vld_ff;
   logic [IDX_W-1:0]       cmp_slot_ff;
   logic                   wr_pend_ff;
   logic [IDX_W-1:0]       wr_addr_ff;
   entry_type              best_ff;
   logic [IDX_W-1:0]       best_slot_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   entry_type              rsp_entry_ff;
   logic [IDX_W-1:0]       rsp_slot_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic [CNT_W-1:0]       last_slot;
   logic                   better;
   logic                   rd_en;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   assign last_slot = count_ff - CNT_W'(1);
   assign rd_en     = cmd.scan_rd | cmd.shift_rd;

   // status to the controller
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.idx_last  = (CNT_W'(idx_ff) == last_slot);
   assign stat.best_last = (CNT_W'(best_slot_ff) == last_slot);
   assign stat.rsp_busy  = rsp_valid_ff & ~rsp_ready;

   // candidate beats best: higher priority, then larger value
   assign better = (rd_data_ff.prio > best_ff.prio) ||
                   ((rd_data_ff.prio == best_ff.prio) && (rd_data_ff.value > best_ff.value));

   // single write port: append on enqueue, shift-down on removal
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_addr_ff;
      wr_data = rd_data_ff;
      if (cmd.enq) begin
         wr_en         = 1'b1;
         wr_addr       = count_ff[IDX_W-1:0];
         wr_data.value = req_value;
         wr_data.prio  = req_prio;
      end else if (wr_pend_ff) begin
         wr_en = 1'b1;
      end
   end

   // fill count and address counter
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      priority if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.shift_start) begin
         idx_in = best_slot_ff + IDX_W'(1);
      end else if (rd_en) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cmp_vld_ff <= cmd.scan_rd;
         wr_pend_ff <= cmd.shift_rd;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // address counter, scan tracking and response payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmp_slot_ff <= idx_ff;
      wr_addr_ff  <= idx_ff - IDX_W'(1);
      if (cmp_vld_ff && ((cmp_slot_ff == '0) || better)) begin
         best_ff      <= rd_data_ff;
         best_slot_ff <= cmp_slot_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= count_ff;
         if (cmd.rsp_found) begin
            rsp_entry_ff <= best_ff;
            rsp_slot_ff  <= best_slot_ff;
         end else begin
            rsp_entry_ff <= '0;
            rsp_slot_ff  <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value     = rsp_entry_ff.value;
   assign rsp_prio      = rsp_entry_ff.prio;
   assign rsp_slot      = SLOT_W'(rsp_slot_ff);
   assign rsp_occupancy = OCC_W'(rsp_count_ff);
   assign rsp_is_empty  = (rsp_count_ff == '0);

   // fill count stays within the store
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // no append into a full store
   a_enq_not_full : assert property (@(posedge clock) disable iff (reset)
      cmd.enq |-> !stat.full)
      else $error("enqueue write while full");

   // response register is never overwritten while its transfer is pending
   a_rsp_no_overrun : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overwritten before transfer");

   // scan compare and shift write never share the read data
   a_rd_exclusive : assert property (@(posedge clock) disable iff (reset)
      !(cmp_vld_ff && wr_pend_ff))
      else $error("scan and shift overlap");

   // a removal takes exactly one entry away
   a_dec_one : assert property (@(posedge clock) disable iff (reset)
      cmd.dec |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("removal did not reduce count by one");

endmodule

// ===== rtl/core/priority_queue_linear_scan.sv =====
// ----------------------------------------------------------------------------
// priority_queue_linear_scan
// Unsorted array priority queue with a single-comparator linear scan.
// ----------------------------------------------------------------------------
// Entries sit in one memory in arrival order. An enqueue goes straight from
// request transfer to response load, as do empty, full and unused requests.
// A peek scans the entries held, reading one entry per cycle through the
// memory's single read port into one comparator. A dequeue then moves the
// entries after the slot removed down one per cycle through the same read
// port and the single write port; removing the last entry moves nothing.
// A new request is taken once the previous response is in the output
// register, so a waiting response does not hold up the next item's work.
module priority_queue_linear_scan #(
   parameter int DEPTH = pqls_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pqls_req_if.sink   req_ch,
   pqls_rsp_if.source rsp_ch
);
   import pqls_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller
   pqls_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // datapath
   pqls_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_ch.item_value),
      .req_prio      (req_ch.item_priority),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_status    (rsp_ch.status),
      .rsp_value     (rsp_ch.out_value),
      .rsp_prio      (rsp_ch.out_priority),
      .rsp_slot      (rsp_ch.out_slot),
      .rsp_occupancy (rsp_ch.occupancy),
      .rsp_is_empty  (rsp_ch.is_empty)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the linear-scan priority queue. Requests go in over the
// request channel with random gaps; every response transfer is checked,
// field by field, against a shadow copy of the queue held in the bench.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pqls_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   // spare opcode, the block must leave its state alone
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // longest dequeue plus margin
   localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic [SLOT_W-1:0]        slot;
      logic [OCC_W-1:0]         occupancy;
      logic                     is_empty;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pqls_req_if req_ch ();
   pqls_rsp_if rsp_ch ();

   priority_queue_linear_scan #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // shadow of the queue contents in arrival order
   logic signed [DATA_W-1:0] held_value [DEPTH];
   logic signed [DATA_W-1:0] held_prio  [DEPTH];
   int                       held_count = 0;

   // responses owed by the block, oldest first
   outcome_type op_outcomes [$];

   int fail_count  = 0;
   int cycle_count = 0;
   int gap_pct     = 0;
   int stall_pct   = 0;

   // clock
   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // apply one operation to the shadow queue and return the response it owes
   function automatic outcome_type apply_queue_op(input logic [OP_W-1:0] op,
                                                   input logic signed [DATA_W-1:0] v,
                                                   input logic signed [DATA_W-1:0] p);
      outcome_type o;
      int          best;
      o = '0;
      o.status = ST_OK;
      best = 0;
      case (op)
         OP_ENQUEUE: begin
            if (held_count >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               held_value[held_count] = v;
               held_prio[held_count]  = p;
               held_count++;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (held_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               // higher priority wins, then larger value, then lower slot
               for (int i = 1; i < held_count; i++) begin
                  if (held_prio[i] > held_prio[best] ||
                      (held_prio[i] == held_prio[best] && held_value[i] > held_value[best]))
                     best = i;
               end
               o.value = held_value[best];
               o.prio  = held_prio[best];
               o.slot  = best[SLOT_W-1:0];
               if (op == OP_DEQUEUE) begin
                  for (int i = best; i < held_count - 1; i++) begin
                     held_value[i] = held_value[i + 1];
                     held_prio[i]  = held_prio[i + 1];
                  end
                  held_count--;
               end
            end
         end
         default: ;
      endcase
      o.occupancy = held_count[OCC_W-1:0];
      o.is_empty  = (held_count == 0);
      return o;
   endfunction

   // data word: full random, small (for ties) or an extreme
   function automatic logic signed [DATA_W-1:0] pick_word();
      logic signed [DATA_W-1:0] w;
      case ($urandom_range(9))
         0, 1, 2: w = $urandom;
         3, 4, 5: w = int'($urandom_range(6)) - 3;
         6:       w = 32'sh7fff_ffff;
         7:       w = 32'sh8000_0000;
         8:       w = '0;
         default: w = '1;
      endcase
      return w;
   endfunction

   // one request transfer, with an optional random gap ahead of it
   task automatic send_op(input logic [OP_W-1:0] op,
                          input logic signed [DATA_W-1:0] v,
                          input logic signed [DATA_W-1:0] p);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_ch.valid         <= 1'b1;
      req_ch.operation     <= op;
      req_ch.item_value    <= v;
      req_ch.item_priority <= p;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      op_outcomes = {op_outcomes, apply_queue_op(op, v, p)};
   endtask

   task automatic send_random_op(input int enq_pct);
      int                r;
      logic [OP_W-1:0]   op;
      r = $urandom_range(99);
      if (r < 4)
         op = OP_UNUSED;
      else if (r < 4 + enq_pct)
         op = OP_ENQUEUE;
      else if ($urandom_range(9) < 6)
         op = OP_DEQUEUE;
      else
         op = OP_PEEK;
      send_op(op, pick_word(), pick_word());
   endtask

   // hold the request side off until every owed response has come back
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (op_outcomes.size() != 0);
   endtask

   // peek, dequeue and spare opcode on an empty queue
   task automatic test_empty_queue();
      send_op(OP_PEEK, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_op(OP_DEQUEUE, 32'sh8000_0000, 32'sh8000_0000);
      send_op(OP_UNUSED, '1, '1);
   endtask

   // all priorities at the minimum, extreme values
   task automatic test_extreme_entries();
      send_op(OP_ENQUEUE, 32'sh8000_0000, 32'sh8000_0000);
      send_op(OP_ENQUEUE, 32'sh7fff_ffff, 32'sh8000_0000);
      send_op(OP_ENQUEUE, '0, 32'sh8000_0000);
      send_op(OP_ENQUEUE, 32'sh7fff_ffff, 32'sh8000_0000);
      send_op(OP_PEEK, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
      send_op(OP_PEEK, '0, '0);
   endtask

   // equal priorities: larger value first, then earliest slot
   task automatic test_tie_breaks();
      send_op(OP_ENQUEUE, 32'sd5, 32'sh7fff_ffff);
      send_op(OP_ENQUEUE, -32'sd1, 32'sh7fff_ffff);
      send_op(OP_ENQUEUE, 32'sd5, 32'sh7fff_ffff);
      send_op(OP_ENQUEUE, 32'sd9, 32'sd0);
      send_op(OP_PEEK, '0, '0);
      send_op(OP_UNUSED, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
      send_op(OP_DEQUEUE, '0, '0);
   endtask

   // bursts that fill, drain or churn the queue under one idling setting
   task automatic test_random_traffic(input int gaps, input int stalls, input int items);
      int sent;
      int n;
      int enq_pct;
      gap_pct   = gaps;
      stall_pct = stalls;
      sent      = 0;
      while (sent < items) begin
         n = $urandom_range(40, 20);
         case ($urandom_range(2))
            0:       enq_pct = 75;
            1:       enq_pct = 25;
            default: enq_pct = 48;
         endcase
         repeat (n) send_random_op(enq_pct);
         sent += n;
      end
      wait_for_drain();
   endtask

   // compare one response transfer with the oldest owed response
   task automatic check_response();
      outcome_type seen;
      outcome_type want;
      seen.status    = rsp_ch.status;
      seen.value     = rsp_ch.out_value;
      seen.prio      = rsp_ch.out_priority;
      seen.slot      = rsp_ch.out_slot;
      seen.occupancy = rsp_ch.occupancy;
      seen.is_empty  = rsp_ch.is_empty;
      if (op_outcomes.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("response with none owed: status %0d value %0d prio %0d slot %0d",
                     seen.status, seen.value, seen.prio, seen.slot);
      end else begin
         want = op_outcomes.pop_front();
         if (seen !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
               $display("mismatch expected: status %0d value %0d prio %0d slot %0d occ %0d empty %0b",
                        want.status, want.value, want.prio, want.slot, want.occupancy,
                        want.is_empty);
               $display("mismatch actual:   status %0d value %0d prio %0d slot %0d occ %0d empty %0b",
                        seen.status, seen.value, seen.prio, seen.slot, seen.occupancy,
                        seen.is_empty);
            end
         end
      end
   endtask

   // response side: check each transfer, then pick the next ready
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_response();
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // test sequence
   initial begin
      req_ch.valid         <= 1'b0;
      req_ch.operation     <= OP_ENQUEUE;
      req_ch.item_value    <= '0;
      req_ch.item_priority <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extreme_entries();
      test_tie_breaks();
      wait_for_drain();

      test_random_traffic(0, 0, 225);
      test_random_traffic(88, 0, 225);
      test_random_traffic(0, 88, 225);
      test_random_traffic(7, 7, 225);

      // let any stray response show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && op_outcomes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
